### hw/rtl/dbl_pkg.sv
// shared types and constants for the button debouncer with long-press detection
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dbl_pkg;

  localparam int COUNT_W    = 8;
  localparam int HOLD_W     = 16;
  localparam int PIN_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 8;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_MAX      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_MAX       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD_THRESHOLD = 3'd4;

  // reset values of the registers
  localparam logic [COUNT_W-1:0] COUNT_MAX_RST      = 8'd20;
  localparam logic [COUNT_W-1:0] RISE_THRESHOLD_RST = 8'd16;
  localparam logic [COUNT_W-1:0] FALL_THRESHOLD_RST = 8'd4;
  localparam logic [HOLD_W-1:0]  HOLD_MAX_RST       = 16'd1500;
  localparam logic [HOLD_W-1:0]  HOLD_THRESHOLD_RST = 16'd1496;

  // beat kinds carried on tuser
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_INIT = 1'b1;

  typedef logic [PIN_W-1:0] pin_idx_t;

  typedef struct packed {
    logic [COUNT_W-1:0] count_max;
    logic [COUNT_W-1:0] rise_threshold;
    logic [COUNT_W-1:0] fall_threshold;
    logic [HOLD_W-1:0]  hold_max;
    logic [HOLD_W-1:0]  hold_threshold;
  } cfg_t;

  // per-pin state word kept in the state memory
  typedef struct packed {
    logic [HOLD_W-1:0]  hold;
    logic               level;
    logic [COUNT_W-1:0] count;
  } pin_state_t;

endpackage

`default_nettype wire

### hw/rtl/button_debounce_long_press_top.sv
// top level of the integrating debouncer with long-press detection
// depends on dbl_pkg, dbl_cfg_regs, dbl_state_mem
`timescale 1ns / 1ps
`default_nettype none

// Integrating debouncer for PIN_COUNT pins with hysteresis and long-low
// detection. Each input beat is one sample (tuser 0) or an initialize
// command (tuser 1) for one pin and gives exactly one result beat. The block
// takes one beat per clock unless the output stalls: the pin state sits in
// a memory with a registered read, the read is issued at acceptance and the
// updated state is written back as the beat leaves the update stage, with a
// bypass when two beats in a row address the same pin. The result is then
// registered on the output and the next beat is taken while it waits. State
// starts at zero after reset through per-entry valid flags, with no clearing
// pass. The user must write configuration only while idle; it is not enforced.
module button_debounce_long_press_top #(
  parameter int PIN_COUNT = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // [2:0] pin_index, [3] level, [7:4] zero
  input  wire logic [dbl_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [0] kind
  input  wire logic                             s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [2:0] pin_index_res, [3] debounced_level, [4] rising_event,
  // [5] falling_event, [6] long_press_event, [7] zero
  output logic [dbl_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
  input  wire logic                             cfg_we,
  input  wire logic [dbl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [dbl_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import dbl_pkg::*;

  localparam int AW    = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
  localparam int EXT_W = 9;

  cfg_t cfg;

  dbl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // input decode
  pin_idx_t         in_pin;
  logic [EXT_W-1:0] in_pin_ext;
  logic [AW-1:0]    in_addr;
  logic             in_in_range;
  logic             accept;
  logic             advance;

  assign in_pin      = s_axis_tdata[PIN_W-1:0];
  assign in_pin_ext  = {{(EXT_W-PIN_W){1'b0}}, in_pin};
  assign in_addr     = in_pin_ext[AW-1:0];
  assign in_in_range = in_pin_ext < EXT_W'(PIN_COUNT);

  // update stage registers
  logic          s1_valid;
  logic          s1_kind;
  pin_idx_t      s1_pin;
  logic          s1_level;
  logic          s1_in_range;
  logic [AW-1:0] s1_addr;
  logic          s1_bypass;
  pin_state_t    s1_bypass_data;

  pin_state_t rd_data;
  pin_state_t cur;
  pin_state_t upd;
  logic       wr_en;
  logic       rise;
  logic       fall;
  logic       longp;

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !s1_valid || advance;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign wr_en         = s1_valid && advance && s1_in_range;

  dbl_state_mem #(
    .DEPTH (PIN_COUNT),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (in_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (s1_addr),
    .wr_data (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // a write to the same pin on the read edge is caught here
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_kind        <= s_axis_tuser;
      s1_pin         <= in_pin;
      s1_level       <= s_axis_tdata[PIN_W];
      s1_in_range    <= in_in_range;
      s1_addr        <= in_addr;
      s1_bypass      <= wr_en && (s1_addr == in_addr);
      s1_bypass_data <= upd;
    end
  end

  assign cur = s1_bypass ? s1_bypass_data : rd_data;

  logic [COUNT_W-1:0] count_step;
  logic [HOLD_W-1:0]  hold_step;

  always_comb begin
    upd        = cur;
    rise       = 1'b0;
    fall       = 1'b0;
    longp      = 1'b0;
    count_step = cur.count;
    hold_step  = cur.hold;
    if (s1_kind == KIND_INIT) begin
      upd.level = s1_level;
      upd.count = s1_level ? cfg.count_max : '0;
      upd.hold  = '0;
    end else if (s1_level) begin
      if (cur.count < cfg.count_max) begin
        count_step = cur.count + COUNT_W'(1);
      end
      upd.count = count_step;
      if (count_step == cfg.rise_threshold && !cur.level) begin
        upd.level = 1'b1;
        upd.hold  = '0;
        rise      = 1'b1;
      end
    end else begin
      if (cur.count != '0) begin
        count_step = cur.count - COUNT_W'(1);
      end
      upd.count = count_step;
      if (count_step == cfg.fall_threshold && cur.level) begin
        upd.level = 1'b0;
        fall      = 1'b1;
      end
      if (cur.hold < cfg.hold_max) begin
        hold_step = cur.hold + HOLD_W'(1);
      end
      upd.hold = hold_step;
      longp    = (hold_step == cfg.hold_threshold) && !upd.level;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      m_axis_tdata <= {1'b0,
                       longp & s1_in_range,
                       fall & s1_in_range,
                       rise & s1_in_range,
                       upd.level & s1_in_range,
                       s1_pin};
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dbl_cfg_regs.sv
// configuration registers of the debouncer
// depends on dbl_pkg
`timescale 1ns / 1ps
`default_nettype none

module dbl_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [dbl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dbl_pkg::CFG_DATA_W-1:0]  cfg_data,
  output dbl_pkg::cfg_t                        cfg
);
  import dbl_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.count_max      <= COUNT_MAX_RST;
      cfg.rise_threshold <= RISE_THRESHOLD_RST;
      cfg.fall_threshold <= FALL_THRESHOLD_RST;
      cfg.hold_max       <= HOLD_MAX_RST;
      cfg.hold_threshold <= HOLD_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COUNT_MAX:      cfg.count_max      <= cfg_data[COUNT_W-1:0];
        REG_RISE_THRESHOLD: cfg.rise_threshold <= cfg_data[COUNT_W-1:0];
        REG_FALL_THRESHOLD: cfg.fall_threshold <= cfg_data[COUNT_W-1:0];
        REG_HOLD_MAX:       cfg.hold_max       <= cfg_data[HOLD_W-1:0];
        REG_HOLD_THRESHOLD: cfg.hold_threshold <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/dbl_state_mem.sv
// per-pin state memory: one write port, one registered read port
// entries never written read as zero through a valid flag per entry; depends on dbl_pkg
`timescale 1ns / 1ps
`default_nettype none

module dbl_state_mem #(
  parameter int DEPTH = 8,
  parameter int AW    = 3
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output dbl_pkg::pin_state_t rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire dbl_pkg::pin_state_t wr_data
);
  import dbl_pkg::*;

  pin_state_t       mem [DEPTH];
  logic [DEPTH-1:0] entry_valid;
  pin_state_t       rd_q;
  logic             rd_valid;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      rd_valid    <= 1'b0;
    end else begin
      if (wr_en) begin
        entry_valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid <= entry_valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_valid ? rd_q : '0;

endmodule

`default_nettype wire

### hw/rtl/dbl_checker.sv
// port-level checks for the debouncer top level, attached by bind
// depends on button_debounce_long_press_top
`timescale 1ns / 1ps
`default_nettype none

module dbl_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_axis_tvalid,
  input wire logic       m_axis_tready,
  input wire logic [7:0] m_axis_tdata
);

  // a stalled result beat holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // nothing leaves right after reset
  assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result beat right after reset");

  // a rising edge leaves the level high and excludes the low-sample events
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[4] |->
      m_axis_tdata[3] && !m_axis_tdata[5] && !m_axis_tdata[6])
    else $error("rising event inconsistent");

  // falling or long press both report a low level
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[5] || m_axis_tdata[6]) |-> !m_axis_tdata[3])
    else $error("low event with level high");

endmodule

bind button_debounce_long_press_top dbl_checker u_dbl_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

### test/tb_top.sv
// self-checking testbench for button_debounce_long_press_top: sends pin samples and
// initialize beats, predicts every result beat and compares it field by field
// depends on dbl_pkg and the rtl top level
`timescale 1ns / 1ps

module tb_top;
  import dbl_pkg::*;

  localparam int PINS = 8;
  // first index past the register list, writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;

  typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PERIODIC} ready_mode_t;

  typedef struct {
    pin_idx_t pin;
    logic     level;
    logic     rising;
    logic     falling;
    logic     long_press;
  } pin_report_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // [2:0] pin_index, [3] level, [7:4] zero
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // [0] kind
  logic                  s_axis_tuser = KIND_TICK;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [2:0] pin_index_res, [3] debounced_level, [4] rising_event,
  // [5] falling_event, [6] long_press_event, [7] zero
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_COUNT_MAX;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the registers and the per-pin state
  cfg_t               regs;
  logic [COUNT_W-1:0] count_q [PINS];
  logic               level_q [PINS];
  logic [HOLD_W-1:0]  hold_q [PINS];

  pin_report_t pending_reports [$];
  int          errors = 0;
  int          burst_left = 0;

  ready_mode_t ready_mode = READY_ALWAYS;
  int          ready_left = 0;
  int          ready_phase = 0;

  button_debounce_long_press_top #(
    .PIN_COUNT(PINS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  // one sample or initialize command applied to the predictor state
  function automatic pin_report_t debounce_predict(input logic kind, input pin_idx_t pin,
                                                   input logic lvl);
    pin_report_t r;
    r.pin = pin;
    r.level = 1'b0;
    r.rising = 1'b0;
    r.falling = 1'b0;
    r.long_press = 1'b0;
    if (int'(pin) < PINS) begin
      if (kind == KIND_INIT) begin
        level_q[pin] = lvl;
        count_q[pin] = lvl ? regs.count_max : '0;
        hold_q[pin] = '0;
      end else if (lvl) begin
        if (count_q[pin] < regs.count_max) count_q[pin] = count_q[pin] + 1'b1;
        if (count_q[pin] == regs.rise_threshold && !level_q[pin]) begin
          level_q[pin] = 1'b1;
          r.rising = 1'b1;
          hold_q[pin] = '0;
        end
      end else begin
        if (count_q[pin] > 0) count_q[pin] = count_q[pin] - 1'b1;
        if (count_q[pin] == regs.fall_threshold && level_q[pin]) begin
          level_q[pin] = 1'b0;
          r.falling = 1'b1;
        end
        // hold advances on every low sample, whatever the debounced level
        if (hold_q[pin] < regs.hold_max) hold_q[pin] = hold_q[pin] + 1'b1;
        if (hold_q[pin] == regs.hold_threshold && !level_q[pin]) r.long_press = 1'b1;
      end
      r.level = level_q[pin];
    end
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    pin_report_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result beat with no expected result: tdata %h", m_axis_tdata);
        errors++;
      end else begin
        want = pending_reports.pop_front();
        check_field("pin_index_res", 32'(want.pin), 32'(m_axis_tdata[2:0]));
        check_field("debounced_level", 32'(want.level), 32'(m_axis_tdata[3]));
        check_field("rising_event", 32'(want.rising), 32'(m_axis_tdata[4]));
        check_field("falling_event", 32'(want.falling), 32'(m_axis_tdata[5]));
        check_field("long_press_event", 32'(want.long_press), 32'(m_axis_tdata[6]));
        check_field("tdata pad", 0, 32'(m_axis_tdata[7]));
      end
    end
  end

  // receiver backpressure: switches between always ready, random and periodic stalls
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode = ready_mode_t'($urandom_range(0, 2));
      ready_left = $urandom_range(64, 300);
    end
    ready_left--;
    ready_phase = (ready_phase + 1) % 7;
    case (ready_mode)
      READY_ALWAYS: m_axis_tready <= 1'b1;
      READY_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default:      m_axis_tready <= (ready_phase < 4);
    endcase
  end

  // sends one beat in bursts with random gaps, predicts it once accepted
  task automatic send_beat(input logic kind, input pin_idx_t pin, input logic lvl);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= {4'b0000, lvl, pin};
    do @(posedge clk); while (!s_axis_tready);
    pending_reports.push_back(debounce_predict(kind, pin, lvl));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (pending_reports.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_COUNT_MAX:      regs.count_max = val[COUNT_W-1:0];
      REG_RISE_THRESHOLD: regs.rise_threshold = val[COUNT_W-1:0];
      REG_FALL_THRESHOLD: regs.fall_threshold = val[COUNT_W-1:0];
      REG_HOLD_MAX:       regs.hold_max = val;
      REG_HOLD_THRESHOLD: regs.hold_threshold = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // 8-bit registers get junk in the upper data bits, which must be dropped
  task automatic write_config(input logic [7:0] cm, input logic [7:0] rise,
                              input logic [7:0] fall, input logic [15:0] hm,
                              input logic [15:0] ht);
    logic [7:0] junk;
    junk = 8'($urandom_range(0, 255));
    write_reg(REG_COUNT_MAX, {junk, cm});
    write_reg(REG_RISE_THRESHOLD, {~junk, rise});
    write_reg(REG_FALL_THRESHOLD, {junk ^ 8'h5a, fall});
    write_reg(REG_HOLD_MAX, hm);
    write_reg(REG_HOLD_THRESHOLD, ht);
    write_reg(REG_SPARE_FIRST + CFG_IDX_W'($urandom_range(0, 2)),
              CFG_DATA_W'($urandom_range(0, 65535)));
  endtask

  task automatic write_random_config();
    logic [7:0]  cm;
    logic [7:0]  rise;
    logic [15:0] hm;
    logic [15:0] ht;
    cm = 8'($urandom_range(1, 24));
    rise = 8'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, cm));
    hm = 16'($urandom_range(1, 40));
    ht = 16'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, hm));
    write_config(cm, rise, 8'($urandom_range(0, cm)), hm, ht);
  endtask

  // press and release runs per pin with some bounce and the odd initialize
  task automatic drive_press_sequences(input int n);
    logic     target [PINS];
    int       run_left [PINS];
    pin_idx_t pin;
    int       span;
    logic     lvl;
    logic     kind;
    for (int p = 0; p < PINS; p++) begin
      target[p] = level_q[p];
      run_left[p] = 0;
    end
    pin = pin_idx_t'($urandom_range(0, PINS - 1));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 1) == 0) pin = pin_idx_t'($urandom_range(0, PINS - 1));
      if (run_left[pin] == 0) begin
        target[pin] = !target[pin];
        span = int'(regs.count_max);
        if (!target[pin]) span += (regs.hold_max > 40) ? 40 : int'(regs.hold_max);
        run_left[pin] = $urandom_range(1, 2 * span + 4);
      end
      run_left[pin]--;
      lvl = target[pin] ^ ($urandom_range(0, 7) == 0);
      kind = ($urandom_range(0, 31) == 0) ? KIND_INIT : KIND_TICK;
      send_beat(kind, pin, lvl);
    end
  endtask

  task automatic test_reset_values();
    drive_press_sequences(150);
    wait_drained();
  endtask

  // tiny thresholds, long press threshold at saturation fires on each low tick after hold saturates
  task automatic test_small_thresholds();
    write_config(8'd3, 8'd2, 8'd1, 16'd3, 16'd3);
    repeat (4) send_beat(KIND_TICK, 3'd0, 1'b1);
    repeat (4) send_beat(KIND_TICK, 3'd0, 1'b0);
    wait_drained();
  endtask

  task automatic test_initialize();
    send_beat(KIND_INIT, 3'd7, 1'b1);
    send_beat(KIND_INIT, 3'd5, 1'b0);
    send_beat(KIND_TICK, 3'd7, 1'b0);
    send_beat(KIND_INIT, 3'd7, 1'b0);
    send_beat(KIND_TICK, 3'd5, 1'b1);
    wait_drained();
  endtask

  // limits lowered below the current count and hold value
  task automatic test_limit_below_count();
    write_config(8'd10, 8'd10, 8'd9, 16'd8, 16'd2);
    send_beat(KIND_INIT, 3'd2, 1'b1);
    repeat (3) send_beat(KIND_TICK, 3'd2, 1'b0);
    wait_drained();
    write_config(8'd2, 8'd6, 8'd6, 16'd1, 16'd3);
    send_beat(KIND_TICK, 3'd2, 1'b0);
    send_beat(KIND_TICK, 3'd2, 1'b1);
    repeat (2) send_beat(KIND_TICK, 3'd2, 1'b0);
    wait_drained();
  endtask

  // full width limits: count saturates at 255, thresholds near the top,
  // count held at zero on low ticks, 16-bit hold limit
  task automatic test_full_range();
    write_config(8'd255, 8'd254, 8'd250, 16'd65535, 16'd3);
    send_beat(KIND_INIT, 3'd4, 1'b1);
    repeat (2) send_beat(KIND_TICK, 3'd4, 1'b1);
    repeat (6) send_beat(KIND_TICK, 3'd4, 1'b0);
    repeat (6) send_beat(KIND_TICK, 3'd4, 1'b1);
    send_beat(KIND_INIT, 3'd4, 1'b0);
    repeat (3) send_beat(KIND_TICK, 3'd4, 1'b0);
    wait_drained();
  endtask

  task automatic test_random_settings();
    write_random_config();
    drive_press_sequences(80);
    wait_drained();
    write_config(8'd1, 8'd1, 8'd0, 16'd1, 16'd1);
    drive_press_sequences(80);
    wait_drained();
    // thresholds the count or hold never reach
    write_config(8'd24, 8'd0, 8'd24, 16'd5, 16'd0);
    drive_press_sequences(80);
    wait_drained();
    repeat (2) begin
      write_random_config();
      drive_press_sequences(80);
      wait_drained();
    end
  endtask

  initial begin
    regs.count_max = COUNT_MAX_RST;
    regs.rise_threshold = RISE_THRESHOLD_RST;
    regs.fall_threshold = FALL_THRESHOLD_RST;
    regs.hold_max = HOLD_MAX_RST;
    regs.hold_threshold = HOLD_THRESHOLD_RST;
    for (int p = 0; p < PINS; p++) begin
      count_q[p] = '0;
      level_q[p] = 1'b0;
      hold_q[p] = '0;
    end
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_reset_values();
    test_small_thresholds();
    test_initialize();
    test_limit_below_count();
    test_full_range();
    test_random_settings();

    if (errors == 0) begin
      $display("PASS button_debounce_long_press_top");
    end else begin
      $display("FAIL button_debounce_long_press_top");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("FAIL button_debounce_long_press_top");
    $finish;
  end

endmodule

### filelist.f
hw/rtl/dbl_pkg.sv
hw/rtl/dbl_cfg_regs.sv
hw/rtl/dbl_state_mem.sv
hw/rtl/button_debounce_long_press_top.sv
hw/rtl/dbl_checker.sv
test/tb_top.sv
